[hdl/gamepad_stick_deadzone_and_button_edges_defines.svh]
// ----------------------------------------------------------------------------
// Gamepad stick dead zone assertion macros
// Shared concurrent assertion forms for the gamepad poll block.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_STICK_DEADZONE_AND_BUTTON_EDGES_DEFINES_SVH
`define GAMEPAD_STICK_DEADZONE_AND_BUTTON_EDGES_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define GSDZ_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("gamepad block assertion failed");

// Condition holds in the cycle after the trigger.
`define GSDZ_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("gamepad block assertion failed");

`endif

[hdl/gsdz_pkg.sv]
// ----------------------------------------------------------------------------
// Gamepad stick dead zone package
// Field widths, register indexes and fixed-point constants of the block.
// ----------------------------------------------------------------------------
package gsdz_pkg;

   localparam int AXIS_W = 16;
   localparam int BTN_W  = 16;
   localparam int ZONE_W = 15;
   localparam int MAG_W  = 16;
   localparam int DIR_W  = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // Register indexes, taken from the word address.
   localparam logic REG_LEFT_ZONE  = 1'b0;
   localparam logic REG_RIGHT_ZONE = 1'b1;

   localparam logic [ZONE_W-1:0] LEFT_ZONE_RESET  = 15'd7849;
   localparam logic [ZONE_W-1:0] RIGHT_ZONE_RESET = 15'd8689;

   localparam logic [ZONE_W-1:0] FULL_RADIUS = 15'd32767;
   localparam logic [16:0]       DIR_ONE     = 17'd16384;
   localparam logic [16:0]       MAG_FULL    = 17'd65535;
   // Twice the full-scale magnitude, the numerator scale of the rescale.
   localparam logic signed [17:0] MAG_SCALE  = 18'sd131070;

endpackage

[hdl/gsdz_req_if.sv]
// ----------------------------------------------------------------------------
// Gamepad poll request channel
// Valid/ready channel carrying one gamepad poll.
// ----------------------------------------------------------------------------
interface gsdz_req_if;
   import gsdz_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     connected;
   logic signed [AXIS_W-1:0] left_x;
   logic signed [AXIS_W-1:0] left_y;
   logic signed [AXIS_W-1:0] right_x;
   logic signed [AXIS_W-1:0] right_y;
   logic        [BTN_W-1:0]  buttons;
   logic        [BTN_W-1:0]  query_mask;

   modport source (output valid, connected, left_x, left_y, right_x, right_y,
                   buttons, query_mask, input ready);
   modport sink   (input valid, connected, left_x, left_y, right_x, right_y,
                   buttons, query_mask, output ready);
endinterface

[hdl/gsdz_rsp_if.sv]
// ----------------------------------------------------------------------------
// Gamepad poll response channel
// Valid/ready channel carrying the processed stick and button status.
// ----------------------------------------------------------------------------
interface gsdz_rsp_if;
   import gsdz_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    is_connected;
   logic        [MAG_W-1:0] left_magnitude;
   logic signed [DIR_W-1:0] left_dir_x;
   logic signed [DIR_W-1:0] left_dir_y;
   logic        [MAG_W-1:0] right_magnitude;
   logic signed [DIR_W-1:0] right_dir_x;
   logic signed [DIR_W-1:0] right_dir_y;
   logic                    mask_held;
   logic                    mask_just_pressed;
   logic                    mask_just_released;

   modport source (output valid, is_connected, left_magnitude, left_dir_x, left_dir_y,
                   right_magnitude, right_dir_x, right_dir_y, mask_held,
                   mask_just_pressed, mask_just_released, input ready);
   modport sink   (input valid, is_connected, left_magnitude, left_dir_x, left_dir_y,
                   right_magnitude, right_dir_x, right_dir_y, mask_held,
                   mask_just_pressed, mask_just_released, output ready);
endinterface

[hdl/gamepad_stick_deadzone_and_button_edges.sv]
// ----------------------------------------------------------------------------
// Gamepad stick dead zone and button edges
// Polls are taken on req_chan, one result per poll leaves on rsp_chan.
// Each poll is handled by a sequencer around one multiplier and one shared
// subtract/compare unit that serves the square root and all divisions.
// A connected poll squares each stick's axes, takes a bitwise square root and
// runs up to three 17-step divisions with setup per stick; a stick with
// zero radius skips its direction divisions and a stick inside its dead
// zone skips the magnitude division. A disconnected poll goes straight to done.
// req_chan.ready is high only while the sequencer is idle; the finished
// result waits in an output register, so a new poll may be taken while the
// previous result is still waiting. If the receiver stalls, the next result
// waits in the sequencer until the output register is free.
// Reset restores both dead-zone registers and clears the stored buttons.
// The dead zones are written over the csr_ port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
`include "gamepad_stick_deadzone_and_button_edges_defines.svh"

module gamepad_stick_deadzone_and_button_edges (
   input  logic                        clock,
   input  logic                        reset,
   gsdz_req_if.sink                    req_chan,
   gsdz_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [gsdz_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [gsdz_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [gsdz_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import gsdz_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQX  = 4'd1;
   localparam logic [3:0] S_SQY  = 4'd2;
   localparam logic [3:0] S_ROOT = 4'd3;
   localparam logic [3:0] S_DXS  = 4'd4;
   localparam logic [3:0] S_DYS  = 4'd5;
   localparam logic [3:0] S_MAGS = 4'd6;
   localparam logic [3:0] S_MAGD = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_NEXT = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   localparam logic [1:0] KIND_DX  = 2'd0;
   localparam logic [1:0] KIND_DY  = 2'd1;
   localparam logic [1:0] KIND_MAG = 2'd2;

   logic [3:0]               state_ff, state_in;
   logic                     sel_ff, sel_in;
   logic [4:0]               count_ff, count_in;
   logic [32:0]              acc_ff, acc_in;
   logic [31:0]              res_ff, res_in;
   logic [31:0]              bit_ff, bit_in;
   logic [34:0]              rem_ff, rem_in;
   logic [34:0]              div_ff, div_in;
   logic [16:0]              quo_ff, quo_in;
   logic [1:0]               kind_ff, kind_in;
   logic [ZONE_W-1:0]        d_ff, d_in;
   logic signed [AXIS_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AXIS_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [ZONE_W-1:0]        lzone_ff, lzone_in, rzone_ff, rzone_in;
   logic [BTN_W-1:0]         cur_ff, cur_in, prev_ff, prev_in;
   logic                     conn_ff, conn_in;
   logic                     held_ff, held_in, press_ff, press_in, rel_ff, rel_in;
   logic [MAG_W-1:0]         mag_ff [2];
   logic [MAG_W-1:0]         mag_in [2];
   logic [DIR_W-1:0]         dx_ff [2];
   logic [DIR_W-1:0]         dx_in [2];
   logic [DIR_W-1:0]         dy_ff [2];
   logic [DIR_W-1:0]         dy_in [2];
   logic                     ovalid_ff, ovalid_in;

   logic [35:0]              op_a, op_b, diff;
   logic                     ge;
   logic [31:0]              trial;
   logic signed [17:0]       mul_a, mul_b;
   logic signed [35:0]       prod;
   logic [15:0]              radius;
   logic [ZONE_W-1:0]        zone, clip_r, m_val, d_val;
   logic signed [AXIS_W-1:0] comp;
   logic [16:0]              abs_c, q_next, q_dir;
   logic [DIR_W-1:0]         dir_val;
   logic                     csr_wr, now_held, before_held;

   // Shared subtract/compare unit: root trial in the root state, else division.
   assign trial = res_ff + bit_ff;
   assign op_a  = (state_ff == S_ROOT) ? {3'b0, acc_ff} : {1'b0, rem_ff};
   assign op_b  = (state_ff == S_ROOT) ? {4'b0, trial} : {1'b0, div_ff};
   assign diff  = op_a - op_b;
   assign ge    = ~diff[35];

   // Stick-dependent operands.
   assign radius = res_ff[15:0];
   assign zone   = sel_ff ? rzone_ff : lzone_ff;
   assign clip_r = (radius > {1'b0, FULL_RADIUS}) ? FULL_RADIUS : radius[ZONE_W-1:0];
   assign m_val  = clip_r - zone;
   assign d_val  = FULL_RADIUS - zone;

   // Shared multiplier: squares of the axes, then the magnitude numerator.
   always_comb begin
      case (state_ff)
         S_SQX: begin
            mul_a = 18'(x_ff);
            mul_b = 18'(x_ff);
         end
         S_SQY: begin
            mul_a = 18'(y_ff);
            mul_b = 18'(y_ff);
         end
         default: begin
            mul_a = {3'b0, m_val};
            mul_b = MAG_SCALE;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // Direction operand and rounded, clipped, signed quotient.
   assign comp    = (state_ff == S_DYS || (state_ff == S_DIV && kind_ff == KIND_DY))
                    ? y_ff : x_ff;
   assign abs_c   = comp[AXIS_W-1] ? (17'd0 - {comp[AXIS_W-1], comp}) : {1'b0, comp};
   assign q_next  = {quo_ff[15:0], ge};
   assign q_dir   = (q_next > DIR_ONE) ? DIR_ONE : q_next;
   assign dir_val = comp[AXIS_W-1] ? (16'd0 - q_dir[15:0]) : q_dir[15:0];

   // Button status against the query mask at acceptance.
   assign now_held    = ((cur_in & req_chan.query_mask) == req_chan.query_mask);
   assign before_held = ((cur_ff & req_chan.query_mask) == req_chan.query_mask);

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_RIGHT_ZONE) ? {17'b0, rzone_ff}
                                                        : {17'b0, lzone_ff};

   assign req_chan.ready = (state_ff == S_IDLE);

   // Sequencer and datapath next state.
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      kind_in  = kind_ff;
      d_in     = d_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      lzone_in = lzone_ff;
      rzone_in = rzone_ff;
      cur_in   = req_chan.connected ? req_chan.buttons : cur_ff;
      prev_in  = prev_ff;
      conn_in  = conn_ff;
      held_in  = held_ff;
      press_in = press_ff;
      rel_in   = rel_ff;
      mag_in   = mag_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      ovalid_in = ovalid_ff && !rsp_chan.ready;

      if (csr_wr) begin
         if (csr_paddr[2] == REG_LEFT_ZONE) begin
            lzone_in = csr_pwdata[ZONE_W-1:0];
         end else begin
            rzone_in = csr_pwdata[ZONE_W-1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            cur_in = cur_ff;
            if (req_chan.valid) begin
               cur_in   = req_chan.connected ? req_chan.buttons : cur_ff;
               prev_in  = cur_ff;
               conn_in  = req_chan.connected;
               held_in  = now_held;
               press_in = now_held && !before_held;
               rel_in   = before_held && !now_held;
               x_in     = req_chan.left_x;
               y_in     = req_chan.left_y;
               rx_in    = req_chan.right_x;
               ry_in    = req_chan.right_y;
               sel_in   = 1'b0;
               for (int i = 0; i < 2; i++) begin
                  mag_in[i] = '0;
                  dx_in[i]  = '0;
                  dy_in[i]  = '0;
               end
               state_in = req_chan.connected ? S_SQX : S_DONE;
            end
         end
         S_SQX: begin
            cur_in   = cur_ff;
            acc_in   = prod[32:0];
            state_in = S_SQY;
         end
         S_SQY: begin
            cur_in   = cur_ff;
            acc_in   = acc_ff + prod[32:0];
            res_in   = '0;
            bit_in   = 32'h4000_0000;
            count_in = 5'd15;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cur_in = cur_ff;
            if (ge) begin
               acc_in = diff[32:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in   = bit_ff >> 2;
            count_in = count_ff - 5'd1;
            if (count_ff == 5'd0) begin
               state_in = S_DXS;
            end
         end
         S_DXS, S_DYS: begin
            cur_in = cur_ff;
            if (radius == 16'd0) begin
               state_in = (state_ff == S_DXS) ? S_DYS : S_MAGS;
            end else begin
               rem_in   = {3'b0, abs_c, 15'b0} + {19'b0, radius};
               div_in   = {2'b0, radius, 17'b0};
               quo_in   = '0;
               count_in = 5'd16;
               kind_in  = (state_ff == S_DXS) ? KIND_DX : KIND_DY;
               state_in = S_DIV;
            end
         end
         S_MAGS: begin
            cur_in = cur_ff;
            if (radius > {1'b0, zone} && zone < FULL_RADIUS) begin
               acc_in   = prod[32:0];
               d_in     = d_val;
               state_in = S_MAGD;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_MAGD: begin
            cur_in   = cur_ff;
            rem_in   = {2'b0, acc_ff} + {20'b0, d_ff};
            div_in   = {3'b0, d_ff, 17'b0};
            quo_in   = '0;
            count_in = 5'd16;
            kind_in  = KIND_MAG;
            state_in = S_DIV;
         end
         S_DIV: begin
            cur_in = cur_ff;
            if (ge) begin
               rem_in = diff[34:0];
            end
            quo_in   = q_next;
            div_in   = div_ff >> 1;
            count_in = count_ff - 5'd1;
            if (count_ff == 5'd0) begin
               case (kind_ff)
                  KIND_DX: begin
                     dx_in[sel_ff] = dir_val;
                     state_in      = S_DYS;
                  end
                  KIND_DY: begin
                     dy_in[sel_ff] = dir_val;
                     state_in      = S_MAGS;
                  end
                  default: begin
                     mag_in[sel_ff] = (q_next > MAG_FULL) ? MAG_FULL[15:0] : q_next[15:0];
                     state_in       = S_NEXT;
                  end
               endcase
            end
         end
         S_NEXT: begin
            cur_in = cur_ff;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               x_in     = rx_ff;
               y_in     = ry_ff;
               state_in = S_SQX;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cur_in = cur_ff;
            if (!ovalid_ff || rsp_chan.ready) begin
               ovalid_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            cur_in   = cur_ff;
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
         lzone_ff  <= LEFT_ZONE_RESET;
         rzone_ff  <= RIGHT_ZONE_RESET;
         cur_ff    <= '0;
         prev_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         lzone_ff  <= lzone_in;
         rzone_ff  <= rzone_in;
         cur_ff    <= cur_in;
         prev_ff   <= prev_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      sel_ff   <= sel_in;
      count_ff <= count_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      kind_ff  <= kind_in;
      d_ff     <= d_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      conn_ff  <= conn_in;
      held_ff  <= held_in;
      press_ff <= press_in;
      rel_ff   <= rel_in;
      mag_ff   <= mag_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
   end

   // Output register, loaded as the sequencer leaves the done state.
   logic                    o_conn_ff, o_held_ff, o_press_ff, o_rel_ff;
   logic [MAG_W-1:0]        o_lmag_ff, o_rmag_ff;
   logic [DIR_W-1:0]        o_ldx_ff, o_ldy_ff, o_rdx_ff, o_rdy_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!ovalid_ff || rsp_chan.ready)) begin
         o_conn_ff  <= conn_ff;
         o_held_ff  <= held_ff;
         o_press_ff <= press_ff;
         o_rel_ff   <= rel_ff;
         o_lmag_ff  <= mag_ff[0];
         o_ldx_ff   <= dx_ff[0];
         o_ldy_ff   <= dy_ff[0];
         o_rmag_ff  <= mag_ff[1];
         o_rdx_ff   <= dx_ff[1];
         o_rdy_ff   <= dy_ff[1];
      end
   end

   assign rsp_chan.valid              = ovalid_ff;
   assign rsp_chan.is_connected       = o_conn_ff;
   assign rsp_chan.left_magnitude     = o_lmag_ff;
   assign rsp_chan.left_dir_x         = o_ldx_ff;
   assign rsp_chan.left_dir_y         = o_ldy_ff;
   assign rsp_chan.right_magnitude    = o_rmag_ff;
   assign rsp_chan.right_dir_x        = o_rdx_ff;
   assign rsp_chan.right_dir_y        = o_rdy_ff;
   assign rsp_chan.mask_held          = o_held_ff;
   assign rsp_chan.mask_just_pressed  = o_press_ff;
   assign rsp_chan.mask_just_released = o_rel_ff;

   // Checks on the sequencer and the result register.
   `GSDZ_ASSERT_NEXT(a_disc_fast, clock, reset,
      req_chan.valid && req_chan.ready && !req_chan.connected, state_ff == S_DONE)
   `GSDZ_ASSERT_NOW(a_busy_not_ready, clock, reset,
      state_ff != S_IDLE, !req_chan.ready)
   `GSDZ_ASSERT_NOW(a_press_held, clock, reset,
      rsp_chan.valid && rsp_chan.mask_just_pressed, rsp_chan.mask_held)
   `GSDZ_ASSERT_NOW(a_disc_zero, clock, reset,
      rsp_chan.valid && !rsp_chan.is_connected,
      rsp_chan.left_magnitude == 16'd0 && rsp_chan.right_magnitude == 16'd0)

endmodule
